FILE: hw/rtl/packed_ascii_value_decoder_top_defines.svh
// Assertion macros for the checker file of the packed value decoder.
// No dependencies; include by bare file name.
`ifndef PACKED_ASCII_VALUE_DECODER_TOP_DEFINES_SVH
`define PACKED_ASCII_VALUE_DECODER_TOP_DEFINES_SVH

// Next-cycle implication, muted while reset is asserted.
`define PAVD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that is also checked across reset.
`define PAVD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: hw/rtl/pavd_pkg.sv
// Shared types, constants and lookup functions of the packed value decoder.
// No dependencies.
`default_nettype none

package pavd_pkg;

    localparam int LINE_CHARS  = 78;
    localparam int COUNT_WIDTH = 24;
    localparam int LINE_W      = $clog2(LINE_CHARS + 1);
    localparam int RAW_W       = 30;
    localparam int DIGIT_W     = 6;
    localparam int POS_W       = 3;
    localparam int BITS_W      = 5;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 8;

    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_WORD_TOTAL   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_BITS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_VALUE = 8'd3;

    typedef struct packed {
        logic             last;
        logic [RAW_W-1:0] raw;
    } t_word;

    // Inverse of the 64-symbol alphabet; foreign characters give zero.
    function automatic logic [DIGIT_W-1:0] char_digit(input logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = DIGIT_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = DIGIT_W'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = DIGIT_W'(c - 8'h61 + 8'd36);
        end else if (c == 8'h7B) begin
            d = 6'd62;
        end else if (c == 8'h7C) begin
            d = 6'd63;
        end
        return d;
    endfunction

    // Characters per value, with the bit count clamped to 1..30.
    function automatic logic [POS_W-1:0] chars_per_value(input logic [BITS_W-1:0] b);
        logic [POS_W-1:0] n;
        if (b <= 5'd6) begin
            n = 3'd1;
        end else if (b <= 5'd12) begin
            n = 3'd2;
        end else if (b <= 5'd18) begin
            n = 3'd3;
        end else if (b <= 5'd24) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

    // Values per line for a given characters-per-value count.
    function automatic logic [LINE_W-1:0] values_per_line(input logic [POS_W-1:0] cpv);
        logic [LINE_W-1:0] v;
        case (cpv)
            3'd1:    v = LINE_W'(LINE_CHARS / 1);
            3'd2:    v = LINE_W'(LINE_CHARS / 2);
            3'd3:    v = LINE_W'(LINE_CHARS / 3);
            3'd4:    v = LINE_W'(LINE_CHARS / 4);
            default: v = LINE_W'(LINE_CHARS / 5);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pavd_front.sv
// Front end: takes characters, maps them to digits, gathers values and
// tracks line and block position. Depends on pavd_pkg.
`default_nettype none

module pavd_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_restart,
    input  wire logic [pavd_pkg::COUNT_WIDTH-1:0]   i_word_total,
    input  wire logic [pavd_pkg::BITS_W-1:0]        i_value_bits,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [7:0]                         i_char,
    output logic                                    o_push,
    output pavd_pkg::t_word                         o_word,
    input  wire logic                               i_full
);

    logic [pavd_pkg::RAW_W-1:0]       r_acc,   n_acc;
    logic [pavd_pkg::POS_W-1:0]       r_pos,   n_pos;
    logic [pavd_pkg::LINE_W-1:0]      r_line,  n_line;
    logic [pavd_pkg::COUNT_WIDTH-1:0] r_words, n_words;
    logic                             r_skip,  n_skip;

    logic                             accept;
    logic [pavd_pkg::RAW_W-1:0]       acc_shift;
    logic [pavd_pkg::POS_W-1:0]       pos_inc;
    logic [pavd_pkg::POS_W-1:0]       cpv;
    logic [pavd_pkg::LINE_W-1:0]      vpl;
    logic [pavd_pkg::LINE_W-1:0]      line_inc;
    logic [pavd_pkg::COUNT_WIDTH-1:0] words_inc;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign cpv       = pavd_pkg::chars_per_value(i_value_bits);
    assign vpl       = pavd_pkg::values_per_line(cpv);
    assign acc_shift = {r_acc[pavd_pkg::RAW_W-pavd_pkg::DIGIT_W-1:0],
                        pavd_pkg::char_digit(i_char)};
    assign pos_inc   = r_pos + 1'b1;
    assign line_inc  = r_line + 1'b1;
    assign words_inc = r_words + 1'b1;

    always_comb begin
        n_acc   = r_acc;
        n_pos   = r_pos;
        n_line  = r_line;
        n_words = r_words;
        n_skip  = r_skip;
        o_push  = 1'b0;
        o_word  = '{last: (words_inc == i_word_total), raw: acc_shift};
        // Drop everything once the block is complete.
        if (accept && (r_words < i_word_total)) begin
            if (i_char == pavd_pkg::NEWLINE) begin
                n_skip = 1'b0;
                n_line = '0;
                n_pos  = '0;
                n_acc  = '0;
            end else if (!r_skip) begin
                n_acc = acc_shift;
                n_pos = pos_inc;
                if (pos_inc >= cpv) begin
                    o_push  = 1'b1;
                    n_acc   = '0;
                    n_pos   = '0;
                    n_words = words_inc;
                    n_line  = line_inc;
                    if (line_inc >= vpl) begin
                        n_line = '0;
                        n_skip = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_acc   <= '0;
            r_pos   <= '0;
            r_line  <= '0;
            r_words <= '0;
            r_skip  <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_words <= n_words;
            r_skip  <= n_skip;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pavd_fifo.sv
// Four-entry queue that carries gathered raw values from front to back.
// Depends on pavd_pkg.
`default_nettype none

module pavd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pavd_pkg::t_word i_wdata,
    output logic                 o_full,
    output logic                 o_valid,
    output pavd_pkg::t_word      o_rdata,
    input  wire logic            i_pop
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    pavd_pkg::t_word    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pavd_back.sv
// Back end: scales each raw value, subtracts the offset and holds the
// result beat for the output stream. Depends on pavd_pkg.
`default_nettype none

module pavd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [pavd_pkg::DATA_W-1:0]   i_scale,
    input  wire logic [pavd_pkg::DATA_W-1:0]   i_offset,
    input  wire logic                          i_valid,
    input  wire pavd_pkg::t_word               i_word,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [pavd_pkg::DATA_W-1:0]        o_data,
    output logic                               o_last
);

    logic                           r_p_valid;
    logic [pavd_pkg::DATA_W-1:0]    r_prod;
    logic                           r_p_last;
    logic                           r_o_valid;
    logic [pavd_pkg::DATA_W-1:0]    r_o_data;
    logic                           r_o_last;
    logic                           out_en;
    logic                           mul_en;
    logic [pavd_pkg::DATA_W-1:0]    prod;

    // Advance each stage when the one after it is empty or moving.
    assign out_en = !r_o_valid || i_ready;
    assign mul_en = !r_p_valid || out_en;
    assign o_pop  = mul_en && i_valid;
    // Low 32 bits of the product are the same for signed and unsigned.
    assign prod   = pavd_pkg::DATA_W'(i_word.raw) * i_scale;

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod   <= prod;
            r_p_last <= i_word.last;
        end
        if (out_en) begin
            r_o_data <= r_prod - i_offset;
            r_o_last <= r_p_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (mul_en) begin
                r_p_valid <= i_valid;
            end
            if (out_en) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

endmodule

`default_nettype wire

FILE: hw/rtl/packed_ascii_value_decoder_top.sv
// Top level of the packed six-bit text value decoder: configuration
// registers, front end, queue and back end. Depends on pavd_pkg and submodules.
//
//  port group    dir  fields (lowest bit first)
//  s_axis        in   tdata[7:0] char_code
//  m_axis        out  tdata[31:0] decoded_value, tlast last_word
//  i_cfg         in   index 0 word_total, 1 value_bits, 2 scale_factor, 3 offset_value
//
// One character is accepted per cycle unless the queue is full; a completed
// value passes through the queue, multiply and subtract registers to m_axis.
// A four-entry queue between front and back absorbs output stalls; s_axis
// drops tready only when it is full. Reset is synchronous, active low, and
// any write to a listed register restarts decoding. No clearing pass.
`default_nettype none

module packed_ascii_value_decoder_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,   // [7:0] char_code
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [pavd_pkg::DATA_W-1:0]             m_axis_tdata,   // [31:0] decoded_value
    output logic                                    m_axis_tlast,
    input  wire logic                               i_cfg_we,
    input  wire logic [pavd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pavd_pkg::DATA_W-1:0]        i_cfg_data
);

    logic [pavd_pkg::COUNT_WIDTH-1:0] r_word_total;
    logic [pavd_pkg::BITS_W-1:0]      r_value_bits;
    logic [pavd_pkg::DATA_W-1:0]      r_scale;
    logic [pavd_pkg::DATA_W-1:0]      r_offset;
    logic                             restart;
    logic                             push;
    logic                             full;
    logic                             q_valid;
    logic                             pop;
    pavd_pkg::t_word                  push_word;
    pavd_pkg::t_word                  q_word;

    always_comb begin
        case (i_cfg_index)
            pavd_pkg::CFG_WORD_TOTAL,
            pavd_pkg::CFG_VALUE_BITS,
            pavd_pkg::CFG_SCALE_FACTOR,
            pavd_pkg::CFG_OFFSET_VALUE: restart = i_cfg_we;
            default:                    restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_total <= '0;
            r_value_bits <= 5'd6;
            r_scale      <= 32'd1;
            r_offset     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pavd_pkg::CFG_WORD_TOTAL:
                    r_word_total <= i_cfg_data[pavd_pkg::COUNT_WIDTH-1:0];
                pavd_pkg::CFG_VALUE_BITS:
                    r_value_bits <= i_cfg_data[pavd_pkg::BITS_W-1:0];
                pavd_pkg::CFG_SCALE_FACTOR: r_scale  <= i_cfg_data;
                pavd_pkg::CFG_OFFSET_VALUE: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pavd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_word_total (r_word_total),
        .i_value_bits (r_value_bits),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_char       (s_axis_tdata),
        .o_push       (push),
        .o_word       (push_word),
        .i_full       (full)
    );

    pavd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_word),
        .o_full  (full),
        .o_valid (q_valid),
        .o_rdata (q_word),
        .i_pop   (pop)
    );

    pavd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scale  (r_scale),
        .i_offset (r_offset),
        .i_valid  (q_valid),
        .i_word   (q_word),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/pavd_checker.sv
// Port-level checks of the packed value decoder and their binding.
// Depends on pavd_pkg and packed_ascii_value_decoder_top_defines.svh.
`default_nettype none
`include "packed_ascii_value_decoder_top_defines.svh"

module pavd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [7:0]                     s_axis_tdata,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [pavd_pkg::DATA_W-1:0]    m_axis_tdata,
    input wire logic                           m_axis_tlast
);

    logic out_stall;
    logic out_idle_open;
    logic ready_ok;

    assign out_stall     = m_axis_tvalid && !m_axis_tready;
    assign out_idle_open = s_axis_tready && !m_axis_tvalid;
    assign ready_ok      = s_axis_tready || m_axis_tvalid ||
                           (s_axis_tvalid && s_axis_tdata != pavd_pkg::NEWLINE);

    // Hold a stalled result beat.
    `PAVD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tlast))
    `PAVD_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, out_stall, $stable(m_axis_tdata))
    // Reset empties the queue and pipeline: no beat out, input open.
    `PAVD_ASSERT_NEXT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready)
    // The input only closes after a stalled output filled the queue.
    `PAVD_ASSERT_NEXT(a_ready_cause, i_clk, i_rst_n, out_idle_open, ready_ok)

endmodule

bind packed_ascii_value_decoder_top pavd_checker u_pavd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
